[hdl/pixel_normal_shader_assert.svh]
// Assertion macros used by the pixel shader checker.
`ifndef PIXEL_NORMAL_SHADER_ASSERT_SVH
`define PIXEL_NORMAL_SHADER_ASSERT_SVH

// same-cycle implication, off during reset
`define PNS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_normal_shader assertion failed");

// next-cycle implication, off during reset
`define PNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_normal_shader assertion failed");

// checked from the reset cycle itself
`define PNS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pixel_normal_shader reset assertion failed");

`endif

[hdl/pns_pkg.sv]
// Shared types and constants for the pixel normal shader.
`default_nettype none

package pns_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_W         = 17;
  localparam int OUT_MAX       = 131071;
  localparam int CFG_IDX_W     = 2;

  localparam logic [15:0] LIGHT_WEIGHT_RST = 16'd29491;
  localparam logic [14:0] LIGHT_MIN_RST    = 15'd4915;
  localparam logic [15:0] BRIGHTNESS_RST   = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_WEIGHT = 2'd0,
    REG_LIGHT_MIN    = 2'd1,
    REG_COLOUR_MODE  = 2'd2,
    REG_BRIGHTNESS   = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SWAP   = 2'd1;
  localparam logic [1:0] MODE_RESET  = MODE_NORMAL;

  // load enables for the three colour-lane stages
  typedef struct packed {
    logic en_s4;
    logic en_s5;
    logic en_s6;
  } lane_ctl_t;

endpackage

`default_nettype wire

[hdl/pns_color_lane.sv]
// One colour channel: ambient*normal, bias and gain, clamp, square.
`default_nettype none

module pns_color_lane #(
  parameter int FRAC_BITS = pns_pkg::FRAC_BITS_DEF,
  parameter int AMBW      = 22
) (
  input  wire logic                     clk,
  input  wire pns_pkg::lane_ctl_t       ctl,
  input  wire logic [AMBW-1:0]          amb,
  input  wire logic signed [15:0]       n,
  input  wire logic [15:0]              brightness,
  output logic [2*FRAC_BITS+1:0]        sq
);

  localparam int F    = FRAC_BITS;
  localparam int ONE  = 1 << F;
  localparam int TW   = AMBW + 17;
  localparam int C1W  = TW - F;
  localparam int C2SW = ((C1W > F + 2) ? C1W : F + 2) + 1;
  localparam int C2W  = C2SW - 1;
  localparam int C3PW = C2W + 17;
  localparam int C3W  = C3PW - F;
  localparam int SQW  = 2 * F + 2;

  logic signed [TW-1:0]   t;
  logic signed [C3PW-1:0] c3p;

  logic signed [C1W-1:0]  c1;
  logic signed [C2SW-1:0] c2_sum;
  logic signed [C2W-1:0]  c2;
  logic signed [C3W-1:0]  c3;
  logic [F:0]             cl;

  always_comb begin
    c1     = t[TW-1:F];
    c2_sum = C2SW'(c1) + $signed(C2SW'(ONE));
    c2     = c2_sum[C2SW-1:1];
    c3     = c3p[C3PW-1:F];
    if (c3[C3W-1]) begin
      cl = '0;
    end else if (c3 > $signed(C3W'(ONE))) begin
      cl = (F+1)'(ONE);
    end else begin
      cl = c3[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s4) begin
      t <= TW'($signed({1'b0, amb})) * TW'(n);
    end
    if (ctl.en_s5) begin
      c3p <= C3PW'(c2) * C3PW'($signed({1'b0, brightness}));
    end
    if (ctl.en_s6) begin
      sq <= SQW'(cl) * SQW'(cl);
    end
  end

endmodule

`default_nettype wire

[hdl/pixel_normal_shader.sv]
// An accepted pixel passes seven register stages, each with its own valid bit.
// Throughput: one pixel per cycle while out_stall is low; a bubble is squeezed
// out, and in_stall rises only when all stages are full.
// Reset: clears every valid bit and loads the register defaults
// (light weight 1.8, light min 0.3, mode 0, brightness 1.0); no clearing pass.
`default_nettype none

module pixel_normal_shader #(
  parameter int FRAC_BITS = pns_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            escaped,
  input  wire logic signed [15:0]              normal_x,
  input  wire logic signed [15:0]              normal_y,
  input  wire logic signed [15:0]              normal_z,
  input  wire logic signed [15:0]              dir_x,
  input  wire logic signed [15:0]              dir_y,
  input  wire logic signed [15:0]              dir_z,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pns_pkg::OUT_W-1:0]            red,
  output logic [pns_pkg::OUT_W-1:0]            green,
  output logic [pns_pkg::OUT_W-1:0]            blue
);

  localparam int F        = FRAC_BITS;
  localparam int ONE      = 1 << F;
  localparam int OW       = pns_pkg::OUT_W;
  localparam int NW       = (F > 15) ? F + 2 : 17;
  localparam int PW       = 16 + NW;
  localparam int AW       = PW + 2;
  localparam int DW       = AW - F;
  localparam int AMBW     = DW + 15 - F;
  localparam int QW       = F + 2;
  localparam int SQW      = 2 * F + 2;
  localparam int MQW      = (QW > OW) ? QW : OW;
  localparam int MAW      = (AMBW > OW) ? AMBW : OW;
  localparam int BACK     = (ONE * 4 + 5) / 10;
  localparam int BACK_SAT = (BACK > pns_pkg::OUT_MAX) ? pns_pkg::OUT_MAX : BACK;

  // configuration registers
  logic [15:0] light_weight;
  logic [14:0] light_min;
  logic [1:0]  colour_mode;
  logic [15:0] brightness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_weight <= pns_pkg::LIGHT_WEIGHT_RST;
      light_min    <= pns_pkg::LIGHT_MIN_RST;
      colour_mode  <= pns_pkg::MODE_RESET;
      brightness   <= pns_pkg::BRIGHTNESS_RST;
    end else if (cfg_valid) begin
      case (pns_pkg::cfg_reg_t'(cfg_index))
        pns_pkg::REG_LIGHT_WEIGHT: light_weight <= cfg_data;
        pns_pkg::REG_LIGHT_MIN:    light_min    <= cfg_data[14:0];
        pns_pkg::REG_COLOUR_MODE:  colour_mode  <= cfg_data[1:0];
        pns_pkg::REG_BRIGHTNESS:   brightness   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage valid and ready; a stage loads when it is empty or draining
  logic [7:1] vld;
  logic [8:1] rdy;

  always_comb begin
    rdy[8] = !out_stall;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // escaped flag travels to the output stage
  logic [6:1] esc;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      esc[1] <= escaped;
    end
    for (int k = 2; k <= 6; k++) begin
      if (rdy[k]) begin
        esc[k] <= esc[k-1];
      end
    end
  end

  // stage 1: dir_i * (normal_i - one)
  logic signed [NW-1:0] nm_x, nm_y, nm_z;
  logic signed [PW-1:0] p_x, p_y, p_z;
  logic signed [15:0]   n1_x, n1_y, n1_z;

  always_comb begin
    nm_x = NW'(normal_x) - $signed(NW'(ONE));
    nm_y = NW'(normal_y) - $signed(NW'(ONE));
    nm_z = NW'(normal_z) - $signed(NW'(ONE));
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_x  <= PW'(dir_x) * PW'(nm_x);
      p_y  <= PW'(dir_y) * PW'(nm_y);
      p_z  <= PW'(dir_z) * PW'(nm_z);
      n1_x <= normal_x;
      n1_y <= normal_y;
      n1_z <= normal_z;
    end
  end

  // stage 2: sum, scale, floor at light_min
  logic signed [AW-1:0] acc;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] lm;
  logic [DW-2:0]        dm;
  logic signed [15:0]   n2_x, n2_y, n2_z;

  always_comb begin
    acc = AW'(p_x) + AW'(p_y) + AW'(p_z);
    d   = acc[AW-1:F];
    lm  = $signed(DW'(light_min));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dm   <= (d < lm) ? lm[DW-2:0] : d[DW-2:0];
      n2_x <= n1_x;
      n2_y <= n1_y;
      n2_z <= n1_z;
    end
  end

  // stage 3: ambient = d * light_weight
  logic [DW+14:0]     amb_prod;
  logic [AMBW-1:0]    amb;
  logic signed [15:0] n3_x, n3_y, n3_z;

  assign amb_prod = (DW+15)'(dm) * (DW+15)'(light_weight);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      amb  <= amb_prod[DW+14:F];
      n3_x <= n2_x;
      n3_y <= n2_y;
      n3_z <= n2_z;
    end
  end

  // ambient rides alongside the lanes for plain lighting mode
  logic [AMBW-1:0] amb4, amb5, amb6;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      amb4 <= amb;
    end
    if (rdy[5]) begin
      amb5 <= amb4;
    end
    if (rdy[6]) begin
      amb6 <= amb5;
    end
  end

  // stages 4 to 6: three colour lanes
  pns_pkg::lane_ctl_t lane_ctl;
  logic [SQW-1:0]     sq_x, sq_y, sq_z;

  assign lane_ctl.en_s4 = rdy[4];
  assign lane_ctl.en_s5 = rdy[5];
  assign lane_ctl.en_s6 = rdy[6];

  pns_color_lane #(.FRAC_BITS(F), .AMBW(AMBW)) u_lane_x (
    .clk(clk), .ctl(lane_ctl), .amb(amb), .n(n3_x), .brightness(brightness), .sq(sq_x)
  );

  pns_color_lane #(.FRAC_BITS(F), .AMBW(AMBW)) u_lane_y (
    .clk(clk), .ctl(lane_ctl), .amb(amb), .n(n3_y), .brightness(brightness), .sq(sq_y)
  );

  pns_color_lane #(.FRAC_BITS(F), .AMBW(AMBW)) u_lane_z (
    .clk(clk), .ctl(lane_ctl), .amb(amb), .n(n3_z), .brightness(brightness), .sq(sq_z)
  );

  // stage 7: scale, saturate, select by mode, or background when escaped
  logic [MQW-1:0] qx_x, qx_y, qx_z;
  logic [MAW-1:0] ax;
  logic [OW-1:0]  c_x, c_y, c_z, c_amb;
  logic [OW-1:0]  red_next, green_next, blue_next;

  always_comb begin
    qx_x  = MQW'(sq_x[SQW-1:F]);
    qx_y  = MQW'(sq_y[SQW-1:F]);
    qx_z  = MQW'(sq_z[SQW-1:F]);
    ax    = MAW'(amb6);
    c_x   = (qx_x > MQW'(pns_pkg::OUT_MAX)) ? OW'(pns_pkg::OUT_MAX) : OW'(qx_x);
    c_y   = (qx_y > MQW'(pns_pkg::OUT_MAX)) ? OW'(pns_pkg::OUT_MAX) : OW'(qx_y);
    c_z   = (qx_z > MQW'(pns_pkg::OUT_MAX)) ? OW'(pns_pkg::OUT_MAX) : OW'(qx_z);
    c_amb = (ax > MAW'(pns_pkg::OUT_MAX)) ? OW'(pns_pkg::OUT_MAX) : OW'(ax);
    if (esc[6]) begin
      red_next   = OW'(BACK_SAT);
      green_next = OW'(BACK_SAT);
      blue_next  = OW'(BACK_SAT);
    end else if (colour_mode == pns_pkg::MODE_NORMAL) begin
      red_next   = c_x;
      green_next = c_y;
      blue_next  = c_z;
    end else if (colour_mode == pns_pkg::MODE_SWAP) begin
      red_next   = c_z;
      green_next = c_y;
      blue_next  = c_x;
    end else begin
      red_next   = c_amb;
      green_next = c_amb;
      blue_next  = c_amb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

`default_nettype wire

[hdl/pns_checker.sv]
// Port-level checks for the pixel normal shader, bound to the top level.
`default_nettype none
`include "pixel_normal_shader_assert.svh"

module pns_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [pns_pkg::OUT_W-1:0]    red,
  input wire logic [pns_pkg::OUT_W-1:0]    green,
  input wire logic [pns_pkg::OUT_W-1:0]    blue
);

  // a held beat keeps its colour
  `PNS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({red, green, blue}))

  // a stalled input beat stays offered
  `PNS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)

  // input backs up only when the pipe is full and the output is blocked
  `PNS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // pipe is empty after reset
  `PNS_ASSERT_RST(a_rst_empty, !out_valid && !in_stall)

endmodule

bind pixel_normal_shader pns_checker u_pns_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .red(red),
  .green(green),
  .blue(blue)
);

`default_nettype wire

[sim/tb_pixel_normal_shader.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pixel_normal_shader: directed corners, all colour modes, random pixels.
module tb_pixel_normal_shader;
  import pns_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE_FX = longint'(1) << FRAC;
  localparam longint BACKGROUND = (ONE_FX * 4 + 5) / 10;
  localparam logic [1:0] MODE_PLAIN = 2'd2;
  localparam logic [1:0] MODE_PLAIN_ALT = 2'd3;
  localparam int IDLE_PCT = 22;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PRINT_CAP = 40;

  typedef struct {
    logic              escaped;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic signed [15:0] dir_x, dir_y, dir_z;
  } pixel_t;

  typedef struct {
    logic [OUT_W-1:0] red, green, blue;
  } colour_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_stall;
  logic escaped;
  logic signed [15:0] normal_x, normal_y, normal_z, dir_x, dir_y, dir_z;
  logic out_valid, out_stall;
  logic [OUT_W-1:0] red, green, blue;

  // shadow copy of the shader registers
  logic [15:0] weight_cfg;
  logic [14:0] floor_cfg;
  logic [1:0]  mode_cfg;
  logic [15:0] gain_cfg;

  colour_t expected_colours[$];
  int mismatch_count;
  int beat_count;
  logic quiet;
  logic rx_hold;
  event hold_start;

  pixel_normal_shader #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .escaped(escaped),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green), .blue(blue)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------- shading predictor ----------------
  function automatic logic [OUT_W-1:0] clip_channel(longint v);
    if (v < 0) return '0;
    if (v > OUT_MAX) return OUT_W'(OUT_MAX);
    return v[OUT_W-1:0];
  endfunction

  function automatic longint lane_colour(longint amb, longint n);
    longint c;
    c = (amb * n) >>> FRAC;
    c = (c + ONE_FX) >>> 1;
    c = (c * longint'(gain_cfg)) >>> FRAC;
    if (c < 0) c = 0;
    if (c > ONE_FX) c = ONE_FX;
    return (c * c) >>> FRAC;
  endfunction

  function automatic colour_t shade_pixel(pixel_t p);
    longint n[3], dv[3], ch[3];
    longint acc, d, amb, t;
    colour_t c;
    if (p.escaped) begin
      c.red = clip_channel(BACKGROUND);
      c.green = clip_channel(BACKGROUND);
      c.blue = clip_channel(BACKGROUND);
      return c;
    end
    n[0] = p.normal_x; n[1] = p.normal_y; n[2] = p.normal_z;
    dv[0] = p.dir_x; dv[1] = p.dir_y; dv[2] = p.dir_z;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += dv[i] * (n[i] - ONE_FX);
    d = acc >>> FRAC;
    if (d < longint'(floor_cfg)) d = longint'(floor_cfg);
    amb = (d * longint'(weight_cfg)) >>> FRAC;
    if (mode_cfg == MODE_NORMAL || mode_cfg == MODE_SWAP) begin
      for (int i = 0; i < 3; i++) ch[i] = lane_colour(amb, n[i]);
      if (mode_cfg == MODE_SWAP) begin
        t = ch[0];
        ch[0] = ch[2];
        ch[2] = t;
      end
    end else begin
      ch[0] = amb; ch[1] = amb; ch[2] = amb;
    end
    c.red = clip_channel(ch[0]);
    c.green = clip_channel(ch[1]);
    c.blue = clip_channel(ch[2]);
    return c;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic pixel_t mk_pixel(logic esc, int nx, int ny, int nz, int dx, int dy, int dz);
    pixel_t p;
    p.escaped = esc;
    p.normal_x = 16'(nx); p.normal_y = 16'(ny); p.normal_z = 16'(nz);
    p.dir_x = 16'(dx); p.dir_y = 16'(dy); p.dir_z = 16'(dz);
    return p;
  endfunction

  // kind 0: any bit pattern, 1: around unit length, 2: small values
  function automatic int random_component(int kind);
    case (kind)
      0: return int'($urandom);
      1: return int'($urandom_range(32768)) - 16384;
      default: return int'($urandom_range(4096)) - 2048;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    int kind;
    kind = $urandom_range(2);
    return mk_pixel($urandom_range(7) == 0,
                    random_component(kind), random_component(kind), random_component(kind),
                    random_component(kind), random_component(kind), random_component(kind));
  endfunction

  task automatic report_error(string msg);
    if (mismatch_count < PRINT_CAP) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_pixel(pixel_t p);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    escaped <= p.escaped;
    normal_x <= p.normal_x; normal_y <= p.normal_y; normal_z <= p.normal_z;
    dir_x <= p.dir_x; dir_y <= p.dir_y; dir_z <= p.dir_z;
    do @(posedge clk); while (in_stall);
    expected_colours.push_back(shade_pixel(p));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
  endtask

  // writes all four registers back to back once the pipeline is empty
  task automatic configure(logic [15:0] weight, logic [15:0] floor_v, logic [15:0] mode,
                           logic [15:0] gain);
    logic [15:0] vals[4];
    cfg_reg_t idx;
    vals = '{weight, floor_v, mode, gain};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_LIGHT_WEIGHT: weight_cfg = vals[i];
        REG_LIGHT_MIN:    floor_cfg = vals[i][14:0];
        REG_COLOUR_MODE:  mode_cfg = vals[i][1:0];
        REG_BRIGHTNESS:   gain_cfg = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------- receiver side ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always begin
    @(hold_start);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    colour_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_colours.size() == 0) begin
        report_error($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want = expected_colours.pop_front();
        if (red !== want.red)
          report_error($sformatf("beat %0d red %0d, expected %0d", beat_count, red, want.red));
        if (green !== want.green)
          report_error($sformatf("beat %0d green %0d, expected %0d", beat_count, green,
                                 want.green));
        if (blue !== want.blue)
          report_error($sformatf("beat %0d blue %0d, expected %0d", beat_count, blue, want.blue));
      end
      beat_count++;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    send_pixel(mk_pixel(1'b1, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(1'b1, -32768, 32767, -32768, 32767, -32768, 32767));
    send_pixel(mk_pixel(1'b0, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(1'b0, 16384, 0, 0, 0, 0, -16384));
    send_pixel(mk_pixel(1'b0, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pixel(mk_pixel(1'b0, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pixel(mk_pixel(1'b0, 32767, 32767, 32767, -32768, -32768, -32768));
    send_pixel(mk_pixel(1'b0, 0, -16384, 16384, -8192, 8192, 0));
  endtask

  task automatic test_colour_modes();
    logic [1:0] modes[4];
    modes = '{MODE_NORMAL, MODE_SWAP, MODE_PLAIN, MODE_PLAIN_ALT};
    foreach (modes[m]) begin
      configure(LIGHT_WEIGHT_RST, {1'b0, LIGHT_MIN_RST}, {14'd0, modes[m]}, BRIGHTNESS_RST);
      // asymmetric normal so a red/blue swap shows
      send_pixel(mk_pixel(1'b0, 12000, -3000, -9000, -4000, 2000, -15000));
      send_pixel(mk_pixel(1'b0, -32768, -32768, -32768, -32768, -32768, -32768));
      send_pixel(mk_pixel(1'b1, 1234, -1234, 77, 5, -5, 9));
      send_pixel(mk_pixel(1'b0, 0, 16384, 0, 0, -16384, 0));
    end
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(16'hFFFF, 16'h7FFF | 16'($urandom_range(1) << 15),
                     16'($urandom) & 16'hFFFC | 16'(ph % 4), 16'hFFFF);
        1: configure(16'h0000, 16'h0000, 16'(ph % 4), 16'h0000);
        default: configure(16'($urandom), 16'($urandom),
                           16'($urandom) & 16'hFFFC | 16'(ph % 4), 16'($urandom));
      endcase
      quiet = (ph == 3);
      repeat (75) send_pixel(random_pixel());
      quiet = 1'b0;
    end
  endtask

  task automatic test_output_hold_off();
    configure(16'($urandom), 16'($urandom_range(32767)), 16'($urandom_range(3)), 16'($urandom));
    quiet = 1'b1;
    -> hold_start;
    repeat (60) send_pixel(random_pixel());
    quiet = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0; cfg_index <= REG_LIGHT_WEIGHT; cfg_data <= '0;
    in_valid <= 1'b0; escaped <= 1'b0;
    normal_x <= '0; normal_y <= '0; normal_z <= '0;
    dir_x <= '0; dir_y <= '0; dir_z <= '0;
    rx_hold <= 1'b0;
    quiet = 1'b0;
    mismatch_count = 0;
    beat_count = 0;
    weight_cfg = LIGHT_WEIGHT_RST;
    floor_cfg = LIGHT_MIN_RST;
    mode_cfg = MODE_RESET;
    gain_cfg = BRIGHTNESS_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_colour_modes();
    test_random_settings();
    test_output_hold_off();

    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && expected_colours.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_colours.size() != 0)
      report_error($sformatf("%0d expected beats never arrived", expected_colours.size()));

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
